FILE: hw/rtl/qrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and helpers for the quadratic root solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int CoefW  = 32;
  localparam int DiscW  = 66;
  localparam int RootW  = 33;
  localparam int NumW   = 35;
  localparam int DenW   = 34;
  localparam int QuotW  = 33;

  // Equation class, settled in the front end
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ANY,
    KIND_LINE,
    KIND_ZEROC,
    KIND_QUAD,
    KIND_DOUBLE,
    KIND_TWO
  } kind_t;

  // Sideband carried along the square root pipeline
  typedef struct packed {
    kind_t             kind;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } sq_side_t;

  // Root count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_ANY  = 2'd3;

  // Magnitude of a 32-bit two's complement value (2^31 fits)
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? (32'd0 - 32'(v)) : 32'(v);
    return r;
  endfunction

endpackage

FILE: hw/rtl/quadratic_root_solver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// Real roots of a*x^2 + b*x + c = 0 on signed fixed-point coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one transaction carries a, b, c packed in s_tdata.
//   Output stream m_*: one transaction per input with root count, the two
//   roots and a saturation flag packed in m_tdata.
//   cfg_wr_en / cfg_wr_data write zero_tolerance (reset value 1); write it
//   only while no transaction is in flight.
// Pipeline: three front stages (classify, products, discriminant), 33
//   square root stages of one root bit each, and 36 divider stages
//   (magnitudes, range check, 33 quotient bits, saturation) plus the
//   output register.
// Throughput: one transaction per cycle unless stalled; all stages advance together.
// Stall: when m_tready is low with a result held, the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated.
// Reset: rst clears every valid bit; the pipeline comes out empty.
// ----------------------------------------------------------------------------
module quadratic_root_solver_core import qrs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,    // coef_a[31:0], coef_b[63:32], coef_c[95:64]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata     // root_count[1:0], root_first[33:2],
                                  // root_second[65:34], overflow[66], zero pad
);

  logic                    adv;
  logic [15:0]             zero_tolerance;

  logic                    fr_valid;
  sq_side_t                fr_side;
  logic [DiscW-1:0]        fr_disc;

  logic                    sq_valid;
  sq_side_t                sq_side;
  logic [RootW-1:0]        sq_root;

  logic signed [NumW-1:0]  num1, num2, neg_b, sroot;
  logic signed [DenW-1:0]  den;

  logic                    dv_valid;
  kind_t                   dv_kind;
  logic [31:0]             q1, q2;
  logic                    o1, o2;

  logic [1:0]              cnt_next;
  logic [31:0]             r1_next, r2_next;
  logic                    ovf_next;

  // Advance the whole pipeline unless a result is held
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Hold the tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_tolerance <= 16'd1;
    end else if (cfg_wr_en) begin
      zero_tolerance <= cfg_wr_data;
    end
  end

  qrs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s_tvalid),
    .coef_a    (s_tdata[31:0]),
    .coef_b    (s_tdata[63:32]),
    .coef_c    (s_tdata[95:64]),
    .tol       (zero_tolerance),
    .out_valid (fr_valid),
    .out_side  (fr_side),
    .out_disc  (fr_disc)
  );

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (fr_valid),
    .in_side   (fr_side),
    .in_disc   (fr_disc),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .out_root  (sq_root)
  );

  // Pick numerators and the shared denominator by equation class
  assign neg_b = NumW'(0) - NumW'(sq_side.b);
  assign sroot = NumW'(sq_root);
  always_comb begin
    num1 = '0;
    num2 = '0;
    den  = DenW'(1);
    case (sq_side.kind)
      KIND_LINE: begin
        // The a slot carries c for a line
        num1 = NumW'(0) - NumW'(sq_side.a);
        den  = DenW'(sq_side.b);
      end
      KIND_ZEROC: begin
        num2 = neg_b;
        den  = DenW'(sq_side.a);
      end
      KIND_DOUBLE: begin
        num1 = neg_b;
        num2 = neg_b;
        den  = {sq_side.a[31], sq_side.a, 1'b0};
      end
      KIND_TWO: begin
        num1 = neg_b - sroot;
        num2 = neg_b + sroot;
        den  = {sq_side.a[31], sq_side.a, 1'b0};
      end
      default: begin
        num1 = '0;
      end
    endcase
  end

  qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (sq_valid),
    .in_kind   (sq_side.kind),
    .num1      (num1),
    .num2      (num2),
    .den       (den),
    .out_valid (dv_valid),
    .out_kind  (dv_kind),
    .quot1     (q1),
    .quot2     (q2),
    .ovf1      (o1),
    .ovf2      (o2)
  );

  // Assemble the result fields
  always_comb begin
    cnt_next = CNT_NONE;
    r1_next  = '0;
    r2_next  = '0;
    ovf_next = 1'b0;
    case (dv_kind)
      KIND_ANY: begin
        cnt_next = CNT_ANY;
      end
      KIND_LINE: begin
        cnt_next = CNT_ONE;
        r1_next  = q1;
        ovf_next = o1;
      end
      KIND_ZEROC: begin
        cnt_next = CNT_TWO;
        r2_next  = q2;
        ovf_next = o2;
      end
      KIND_DOUBLE: begin
        cnt_next = CNT_ONE;
        r1_next  = q1;
        r2_next  = q1;
        ovf_next = o1;
      end
      KIND_TWO: begin
        cnt_next = CNT_TWO;
        r1_next  = q1;
        r2_next  = q2;
        ovf_next = o1 | o2;
      end
      default: begin
        cnt_next = CNT_NONE;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dv_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {5'd0, ovf_next, r2_next, r1_next, cnt_next};
    end
  end

  // An empty output stage always takes the next transaction
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output stage");

  // No roots or any number carry zero roots and no overflow
  a_empty_roots: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == CNT_NONE || m_tdata[1:0] == CNT_ANY)
      |-> m_tdata[65:2] == '0 && !m_tdata[66])
    else $error("roots present for a no-root or any-root result");

  // A held result does not change
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata[66:0]))
    else $error("result changed while stalled");

endmodule

FILE: hw/rtl/qrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_front
// Classifies the coefficients, squares and multiplies them and forms the
// exact discriminant over three register stages.
// ----------------------------------------------------------------------------
module qrs_front import qrs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [CoefW-1:0]  coef_a,
  input  logic signed [CoefW-1:0]  coef_b,
  input  logic signed [CoefW-1:0]  coef_c,
  input  logic [15:0]              tol,
  output logic                     out_valid,
  output sq_side_t                 out_side,
  output logic [DiscW-1:0]         out_disc
);

  logic                    v1, v2, v3;
  logic signed [31:0]      a1, b1, c1, a2, b2, a3, b3;
  logic                    na1, nb1, nc1;
  kind_t                   kind2, kind3;
  logic [63:0]             bb2, ac2;
  logic                    dsg2;
  logic [DiscW-1:0]        d3;

  logic                    na, nb, nc;
  kind_t                   kind_pre;
  logic [DiscW-1:0]        bb_w, ac4_w, d_w, tol_w;
  logic                    neg_w;
  kind_t                   kind_fin;

  // Near-zero tests on the raw coefficients
  assign na = mag32(coef_a) <= {16'd0, tol};
  assign nb = mag32(coef_b) <= {16'd0, tol};
  assign nc = mag32(coef_c) <= {16'd0, tol};

  // Stage 1: capture coefficients and zero flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a1  <= coef_a;
      b1  <= coef_b;
      c1  <= coef_c;
      na1 <= na;
      nb1 <= nb;
      nc1 <= nc;
    end
  end

  // Preliminary class
  always_comb begin
    if (na1) begin
      if (nb1) kind_pre = nc1 ? KIND_ANY : KIND_NONE;
      else     kind_pre = KIND_LINE;
    end else if (nc1) begin
      kind_pre = KIND_ZEROC;
    end else begin
      kind_pre = KIND_QUAD;
    end
  end

  // Stage 2: products b*b and a*c on magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      kind2 <= kind_pre;
      // A line has no use for a, so its slot carries c instead
      a2    <= (kind_pre == KIND_LINE) ? c1 : a1;
      b2    <= b1;
      bb2   <= mag32(b1) * mag32(b1);
      ac2   <= mag32(a1) * mag32(c1);
      dsg2  <= a1[31] ^ c1[31];
    end
  end

  // Discriminant b*b - 4*a*c, exact
  assign bb_w  = {2'b00, bb2};
  assign ac4_w = {ac2, 2'b00};
  assign tol_w = DiscW'({tol, {FRAC_BITS{1'b0}}});
  always_comb begin
    neg_w = 1'b0;
    d_w   = '0;
    if (dsg2) begin
      d_w = bb_w + ac4_w;
    end else if (ac4_w > bb_w) begin
      neg_w = 1'b1;
    end else begin
      d_w = bb_w - ac4_w;
    end
    kind_fin = kind2;
    if (kind2 == KIND_QUAD) begin
      if (neg_w)              kind_fin = KIND_NONE;
      else if (d_w <= tol_w)  kind_fin = KIND_DOUBLE;
      else                    kind_fin = KIND_TWO;
    end
  end

  // Stage 3: register discriminant and final class
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      kind3 <= kind_fin;
      a3    <= a2;
      b3    <= b2;
      d3    <= d_w;
    end
  end

  assign out_valid     = v3;
  assign out_side.kind = kind3;
  assign out_side.a    = a3;
  assign out_side.b    = b3;
  assign out_disc      = d3;

endmodule

FILE: hw/rtl/qrs_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_sqrt
// Floor square root of the 66-bit discriminant, one root bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt import qrs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  sq_side_t          in_side,
  input  logic [DiscW-1:0]  in_disc,
  output logic              out_valid,
  output sq_side_t          out_side,
  output logic [RootW-1:0]  out_root
);

  localparam int Steps = RootW;

  logic              vld  [0:Steps];
  sq_side_t          side [0:Steps];
  logic [DiscW-1:0]  dd   [0:Steps];
  logic [RootW:0]    rem  [0:Steps];
  logic [RootW-1:0]  root [0:Steps];

  assign vld[0]  = in_valid;
  assign side[0] = in_side;
  assign dd[0]   = in_disc;
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int P = Steps - 1 - k;
    logic [RootW+2:0] r2;
    logic [RootW+2:0] trial;
    logic             take;

    // Bring down two bits and try the next root bit
    assign r2    = {rem[k], dd[k][2*P+1 -: 2]};
    assign trial = {1'b0, root[k], 2'b01};
    assign take  = r2 >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        side[k+1] <= side[k];
        dd[k+1]   <= dd[k];
        rem[k+1]  <= take ? (RootW+1)'(r2 - trial) : (RootW+1)'(r2);
        root[k+1] <= {root[k][RootW-2:0], take};
      end
    end
  end

  assign out_valid = vld[Steps];
  assign out_side  = side[Steps];
  assign out_root  = root[Steps];

endmodule

FILE: hw/rtl/qrs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div
// Two fixed-point quotients over one shared denominator, restoring division
// with one quotient bit per stage, then saturation to 32 bits.
// ----------------------------------------------------------------------------
module qrs_div import qrs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  kind_t                   in_kind,
  input  logic signed [NumW-1:0]  num1,
  input  logic signed [NumW-1:0]  num2,
  input  logic signed [DenW-1:0]  den,
  output logic                    out_valid,
  output kind_t                   out_kind,
  output logic [31:0]             quot1,
  output logic [31:0]             quot2,
  output logic                    ovf1,
  output logic                    ovf2
);

  localparam int NW    = NumW + FRAC_BITS;
  localparam int Steps = QuotW;

  // Stage A: magnitudes and signs
  logic              va;
  kind_t             ka;
  logic [NW-1:0]     n1a, n2a;
  logic [QuotW-1:0]  da;
  logic              s1a, s2a;
  logic [NumW-1:0]   m1, m2;
  logic [DenW-1:0]   md;

  assign m1 = num1[NumW-1] ? (NumW'(0) - NumW'(num1)) : NumW'(num1);
  assign m2 = num2[NumW-1] ? (NumW'(0) - NumW'(num2)) : NumW'(num2);
  assign md = den[DenW-1]  ? (DenW'(0) - DenW'(den))  : DenW'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ka  <= in_kind;
      n1a <= {m1, {FRAC_BITS{1'b0}}};
      n2a <= {m2, {FRAC_BITS{1'b0}}};
      da  <= md[QuotW-1:0];
      s1a <= num1[NumW-1] ^ den[DenW-1];
      s2a <= num2[NumW-1] ^ den[DenW-1];
    end
  end

  // Lane arrays: remainder, low dividend bits, quotient
  logic              vld [0:Steps];
  kind_t             knd [0:Steps];
  logic [QuotW-1:0]  dv  [0:Steps];
  logic [QuotW-1:0]  r1  [0:Steps];
  logic [QuotW-1:0]  r2  [0:Steps];
  logic [QuotW-1:0]  lo1 [0:Steps];
  logic [QuotW-1:0]  lo2 [0:Steps];
  logic [QuotW-1:0]  q1  [0:Steps];
  logic [QuotW-1:0]  q2  [0:Steps];
  logic              ov1 [0:Steps];
  logic              ov2 [0:Steps];
  logic              sg1 [0:Steps];
  logic              sg2 [0:Steps];

  // Stage B: quotient range check and starting remainder
  logic [NW-QuotW-1:0] hi1, hi2;
  logic                big1, big2;
  assign hi1  = n1a[NW-1:QuotW];
  assign hi2  = n2a[NW-1:QuotW];
  assign big1 = QuotW'(hi1) >= da;
  assign big2 = QuotW'(hi2) >= da;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= va;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      knd[0] <= ka;
      dv[0]  <= da;
      r1[0]  <= big1 ? '0 : QuotW'(hi1);
      r2[0]  <= big2 ? '0 : QuotW'(hi2);
      lo1[0] <= n1a[QuotW-1:0];
      lo2[0] <= n2a[QuotW-1:0];
      q1[0]  <= '0;
      q2[0]  <= '0;
      ov1[0] <= big1;
      ov2[0] <= big2;
      sg1[0] <= s1a;
      sg2[0] <= s2a;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int B = Steps - 1 - k;
    logic [QuotW:0] t1, t2;
    logic           g1, g2;

    // Shift in the next dividend bit and subtract where it fits
    assign t1 = {r1[k], lo1[k][B]};
    assign t2 = {r2[k], lo2[k][B]};
    assign g1 = t1 >= {1'b0, dv[k]};
    assign g2 = t2 >= {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        knd[k+1] <= knd[k];
        dv[k+1]  <= dv[k];
        lo1[k+1] <= lo1[k];
        lo2[k+1] <= lo2[k];
        r1[k+1]  <= g1 ? QuotW'(t1 - {1'b0, dv[k]}) : QuotW'(t1);
        r2[k+1]  <= g2 ? QuotW'(t2 - {1'b0, dv[k]}) : QuotW'(t2);
        q1[k+1]  <= {q1[k][QuotW-2:0], g1};
        q2[k+1]  <= {q2[k][QuotW-2:0], g2};
        ov1[k+1] <= ov1[k];
        ov2[k+1] <= ov2[k];
        sg1[k+1] <= sg1[k];
        sg2[k+1] <= sg2[k];
      end
    end
  end

  // Saturate to the signed 32-bit range
  localparam logic [QuotW-1:0] NegLim = QuotW'(33'h0_8000_0000);
  localparam logic [QuotW-1:0] PosLim = QuotW'(33'h0_7FFF_FFFF);

  logic [31:0] f1, f2;
  logic        sat1, sat2;
  always_comb begin
    if (sg1[Steps]) begin
      sat1 = ov1[Steps] || (q1[Steps] > NegLim);
      f1   = sat1 ? 32'h8000_0000 : (32'd0 - q1[Steps][31:0]);
    end else begin
      sat1 = ov1[Steps] || (q1[Steps] > PosLim);
      f1   = sat1 ? 32'h7FFF_FFFF : q1[Steps][31:0];
    end
    if (sg2[Steps]) begin
      sat2 = ov2[Steps] || (q2[Steps] > NegLim);
      f2   = sat2 ? 32'h8000_0000 : (32'd0 - q2[Steps][31:0]);
    end else begin
      sat2 = ov2[Steps] || (q2[Steps] > PosLim);
      f2   = sat2 ? 32'h7FFF_FFFF : q2[Steps][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[Steps];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_kind <= knd[Steps];
      quot1    <= f1;
      quot2    <= f2;
      ovf1     <= sat1;
      ovf2     <= sat2;
    end
  end

endmodule
